@@ hw/rtl/rvc_pkg.sv @@
`timescale 1ns / 1ps

package rvc_pkg;

    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int DIST_W   = 13;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int SUMSQ_W  = SQ_W + 1;
    localparam int INV_W    = 32;
    localparam int PROD_W   = SUMSQ_W + INV_W;
    localparam int K_W      = 12;
    localparam int R2_W     = 16;
    localparam int SCALED_W = 18;
    localparam int FACTOR_W = 18;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // r^2 = prod >> 24, Q0.16
    localparam int R2_LSB = 24;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_STRENGTH = 2'd2;
    localparam logic [1:0] REG_INV_NORM = 2'd3;

    localparam logic [R2_W-1:0]     R2_MAX     = '1;
    localparam logic [FACTOR_W:0]   FACTOR_ONE = (FACTOR_W + 1)'(1) << 16;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;
    localparam logic [7:0]          CHAN_MAX   = 8'hFF;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [7:0]         blue_in;
        logic [7:0]         green_in;
        logic [7:0]         red_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       clipped;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [K_W-1:0]   strength;
        logic [INV_W-1:0] inv_norm;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        width:    DIM_W'(640),
        height:   DIM_W'(480),
        strength: K_W'(512),
        inv_norm: INV_W'(1717987)
    };

    // returns {clip, value}: (c * factor) >> 16, clamped to 255
    function automatic logic [8:0] scale_chan(input logic [7:0] c,
                                              input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W+7:0] p;
        logic                clip;
        p    = c * f;
        clip = |p[FACTOR_W+7:24];
        return {clip, clip ? CHAN_MAX : p[23:16]};
    endfunction

endpackage

@@ hw/rtl/rvc_regs.sv @@
`timescale 1ns / 1ps

module rvc_regs import rvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:    cfg_next.width    = pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_next.height   = pwdata[DIM_W-1:0];
                REG_STRENGTH: cfg_next.strength = pwdata[K_W-1:0];
                REG_INV_NORM: cfg_next.inv_norm = pwdata[INV_W-1:0];
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:    prdata = DATA_W'(cfg_reg.width);
            REG_HEIGHT:   prdata = DATA_W'(cfg_reg.height);
            REG_STRENGTH: prdata = DATA_W'(cfg_reg.strength);
            REG_INV_NORM: prdata = DATA_W'(cfg_reg.inv_norm);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/rvc_radius.sv @@
`timescale 1ns / 1ps

// Stages 1-4: doubled offsets, squares, sum, scale by inverse norm.
module rvc_radius import rvc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              take,
    input  pix_in_t           item,
    input  cfg_t              cfg,
    output logic              prod_valid,
    output logic [PROD_W-1:0] prod,
    output rgb_t              prod_pix
);

    localparam int MB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    logic [COORD_W-1:0]  col_m;
    logic [COORD_W-1:0]  row_m;
    logic [DIST_W-1:0]   two_col;
    logic [DIST_W-1:0]   two_row;
    logic [DIST_W-1:0]   dx_next;
    logic [DIST_W-1:0]   dy_next;
    logic [SQ_W-1:0]     dx2_next;
    logic [SQ_W-1:0]     dy2_next;
    logic [SUMSQ_W-1:0]  sumsq_next;
    logic [PROD_W-1:0]   prod_next;

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic                s3_valid_reg;
    logic                s4_valid_reg;
    logic [DIST_W-1:0]   dx_reg;
    logic [DIST_W-1:0]   dy_reg;
    logic [SQ_W-1:0]     dx2_reg;
    logic [SQ_W-1:0]     dy2_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [PROD_W-1:0]   prod_reg;
    rgb_t                s1_pix_reg;
    rgb_t                s2_pix_reg;
    rgb_t                s3_pix_reg;
    rgb_t                s4_pix_reg;

    assign col_m   = COORD_W'(item.column[MB-1:0]);
    assign row_m   = COORD_W'(item.row[MB-1:0]);
    assign two_col = {col_m, 1'b0};
    assign two_row = {row_m, 1'b0};

    assign dx_next    = (two_col >= cfg.width)  ? two_col - cfg.width  : cfg.width  - two_col;
    assign dy_next    = (two_row >= cfg.height) ? two_row - cfg.height : cfg.height - two_row;
    assign dx2_next   = dx_reg * dx_reg;
    assign dy2_next   = dy_reg * dy_reg;
    assign sumsq_next = SUMSQ_W'(dx2_reg) + SUMSQ_W'(dy2_reg);
    assign prod_next  = sumsq_reg * cfg.inv_norm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            s1_pix_reg <= '{blue: item.blue_in, green: item.green_in, red: item.red_in};
            dx2_reg    <= dx2_next;
            dy2_reg    <= dy2_next;
            s2_pix_reg <= s1_pix_reg;
            sumsq_reg  <= sumsq_next;
            s3_pix_reg <= s2_pix_reg;
            prod_reg   <= prod_next;
            s4_pix_reg <= s3_pix_reg;
        end
    end

    assign prod_valid = s4_valid_reg;
    assign prod       = prod_reg;
    assign prod_pix   = s4_pix_reg;

endmodule

@@ hw/rtl/rvc_gain.sv @@
`timescale 1ns / 1ps

// Stages 5-7: r^2 saturation and k*r^2, gain factor, per-channel scaling.
module rvc_gain import rvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              prod_valid,
    input  logic [PROD_W-1:0] prod,
    input  rgb_t              prod_pix,
    input  logic [K_W-1:0]    strength,
    output logic              done,
    output pix_out_t          result
);

    logic [R2_W-1:0]       r2;
    logic [K_W+R2_W-1:0]   kr2;
    logic [FACTOR_W:0]     f_sum;
    logic [FACTOR_W-1:0]   factor_next;
    logic [8:0]            b_sc;
    logic [8:0]            g_sc;
    logic [8:0]            r_sc;
    pix_out_t              result_next;

    logic                  s5_valid_reg;
    logic                  s6_valid_reg;
    logic                  s7_valid_reg;
    logic [SCALED_W-1:0]   scaled_reg;
    logic [FACTOR_W-1:0]   factor_reg;
    pix_out_t              result_reg;
    rgb_t                  s5_pix_reg;
    rgb_t                  s6_pix_reg;

    // anything at or above 2^40 before the shift saturates r^2
    assign r2    = (|prod[PROD_W-1:R2_LSB+R2_W]) ? R2_MAX : prod[R2_LSB+R2_W-1:R2_LSB];
    assign kr2   = strength * r2;
    assign f_sum = FACTOR_ONE + (FACTOR_W + 1)'(scaled_reg);
    assign factor_next = f_sum[FACTOR_W] ? FACTOR_MAX : f_sum[FACTOR_W-1:0];

    assign b_sc = scale_chan(s6_pix_reg.blue,  factor_reg);
    assign g_sc = scale_chan(s6_pix_reg.green, factor_reg);
    assign r_sc = scale_chan(s6_pix_reg.red,   factor_reg);
    assign result_next = '{
        blue_out:  b_sc[7:0],
        green_out: g_sc[7:0],
        red_out:   r_sc[7:0],
        clipped:   b_sc[8] | g_sc[8] | r_sc[8]
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= prod_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= kr2[K_W+R2_W-1:10];
            s5_pix_reg <= prod_pix;
            factor_reg <= factor_next;
            s6_pix_reg <= s5_pix_reg;
            result_reg <= result_next;
        end
    end

    assign done   = s7_valid_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/rvc_outbuf.sv @@
`timescale 1ns / 1ps

// Output register plus skid entry; space is registered so the input side
// never sees res_ready combinationally.
module rvc_outbuf import rvc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pix_out_t data,
    input  logic     res_ready,
    output logic     res_valid,
    output pix_out_t res,
    output logic     space
);

    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    pix_out_t out_reg;
    pix_out_t out_next;
    pix_out_t skid_reg;
    pix_out_t skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !res_ready)
        begin
            if (push)
            begin
                skid_valid_next = 1'b1;
                skid_next       = data;
            end
        end
        else if (skid_valid_reg)
        begin
            // push is held off while the skid entry is full
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = push;
            if (push)
            begin
                out_next = data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign space     = !skid_valid_reg;

endmodule

@@ hw/rtl/radial_vignette_correction.sv @@
`timescale 1ns / 1ps
// The accepting edge loads stage 1; the pixel moves through the 7 pipeline stages
// into the output register, where res_valid rises.
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds only while the skid entry behind the output register is occupied.
// Reset (rst_n low, async): all valid bits clear, registers return to
// width 640, height 480, strength 512, inverse_norm 1717987.
module radial_vignette_correction import rvc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  pix_in_t           pix,
    output logic              res_valid,
    input  logic              res_ready,
    output pix_out_t          res
);

    cfg_t              cfg;
    logic              en;
    logic              prod_valid;
    logic [PROD_W-1:0] prod;
    rgb_t              prod_pix;
    logic              done;
    pix_out_t          result;

    assign pix_ready = en;

    rvc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rvc_radius #(
        .COORD_BITS (COORD_BITS)
    ) u_radius (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (pix_valid && en),
        .item       (pix),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_pix   (prod_pix)
    );

    rvc_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_pix   (prod_pix),
        .strength   (cfg.strength),
        .done       (done),
        .result     (result)
    );

    rvc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (done && en),
        .data      (result),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .space     (en)
    );

endmodule

@@ hw/rtl/rvc_checker.sv @@
`timescale 1ns / 1ps

module rvc_checker import rvc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              pix_valid,
    input logic              pix_ready,
    input pix_in_t           pix,
    input logic              res_valid,
    input logic              res_ready,
    input pix_out_t          res
);

    // 7 pipeline stages, output register and skid entry
    localparam logic [3:0] MAX_INFLIGHT = 4'd9;

    logic       acc_in;
    logic       acc_out;
    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    assign acc_in  = pix_valid && pix_ready;
    assign acc_out = res_valid && res_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (acc_in && !acc_out)
        begin
            inflight_next = inflight_reg + 4'd1;
        end
        else if (!acc_in && acc_out)
        begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 4'd0)
        else $error("result without an accepted pixel");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= MAX_INFLIGHT)
        else $error("more pixels in flight than storage");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pix_ready) |-> $past(res_valid && !res_ready))
        else $error("pix_ready dropped without output backpressure");

endmodule

bind radial_vignette_correction rvc_checker u_rvc_checker (.*);
